>>> rtl/u16u8_pkg.sv
// package: beat types, encoder result type and surrogate constants
`timescale 1ns / 1ps

package u16u8_pkg;

    typedef struct packed {
        logic [20:0] code_unit;
        logic        last_unit;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       last_of_run;
        logic       string_end;
    } out_beat_t;

    // up to four bytes of one code point, byte 0 first, plus their count
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } enc_t;

    localparam logic [20:0] ONE_BYTE_MAX   = 21'h00007F;
    localparam logic [20:0] TWO_BYTE_MAX   = 21'h0007FF;
    localparam logic [20:0] THREE_BYTE_MAX = 21'h00FFFF;
    localparam logic [20:0] PLANE1_BASE    = 21'h010000;

    localparam logic [7:0] LEAD2  = 8'hC0;
    localparam logic [7:0] LEAD3  = 8'hE0;
    localparam logic [7:0] LEAD4  = 8'hF0;
    localparam logic [7:0] CONT   = 8'h80;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;

    localparam int unsigned MAX_BYTES = 6;

endpackage

>>> rtl/u16u8_enc.sv
// utf-8 encoder for one 21-bit code point
`timescale 1ns / 1ps

module u16u8_enc (
    input  logic [20:0]       cp,
    output u16u8_pkg::enc_t   enc
);

    always_comb begin
        enc = '0;
        if (cp <= u16u8_pkg::ONE_BYTE_MAX) begin
            enc.bytes[0] = {1'b0, cp[6:0]};
            enc.count    = 3'd1;
        end else if (cp <= u16u8_pkg::TWO_BYTE_MAX) begin
            enc.bytes[0] = u16u8_pkg::LEAD2 | {3'b000, cp[10:6]};
            enc.bytes[1] = u16u8_pkg::CONT | {2'b00, cp[5:0]};
            enc.count    = 3'd2;
        end else if (cp <= u16u8_pkg::THREE_BYTE_MAX) begin
            enc.bytes[0] = u16u8_pkg::LEAD3 | {4'b0000, cp[15:12]};
            enc.bytes[1] = u16u8_pkg::CONT | {2'b00, cp[11:6]};
            enc.bytes[2] = u16u8_pkg::CONT | {2'b00, cp[5:0]};
            enc.count    = 3'd3;
        end else begin
            enc.bytes[0] = u16u8_pkg::LEAD4 | {5'b00000, cp[20:18]};
            enc.bytes[1] = u16u8_pkg::CONT | {2'b00, cp[17:12]};
            enc.bytes[2] = u16u8_pkg::CONT | {2'b00, cp[11:6]};
            enc.bytes[3] = u16u8_pkg::CONT | {2'b00, cp[5:0]};
            enc.count    = 3'd4;
        end
    end

endmodule

>>> rtl/utf16_to_utf8_transcoder.sv
// top level: utf-16 / utf-32 unit to utf-8 byte stream transcoder
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------------
//   s_       | in        | s_valid / s_ready     | code_unit[20:0], last_unit
//   m_       | out       | m_valid / m_ready     | utf8_byte[7:0], last_of_run, string_end
//   cfg_     | in        | cfg_valid / cfg_ready | cfg_data = pair_surrogates
//
// an input beat is encoded in the cycle it is accepted into a 6-byte result buffer
// the buffer drains one byte per cycle while m_ready is high; a unit yields n = 0..6 bytes
// a held high surrogate produces no bytes and the next beat is taken the cycle after
// the next beat is accepted in the same cycle the final buffered byte is taken
// aresetn (synchronous, active low) sets pairing on, drops the held surrogate, empties buffer
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  u16u8_pkg::in_beat_t   s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output u16u8_pkg::out_beat_t  m_data,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);

    // configuration and surrogate hold state
    logic        pair_reg;
    logic        held_valid_reg, held_valid_next;
    logic [15:0] held_reg, held_next;

    // result buffer and byte serializer
    logic [7:0]  buf_reg [u16u8_pkg::MAX_BYTES];
    logic [7:0]  buf_next [u16u8_pkg::MAX_BYTES];
    logic [2:0]  cnt_reg, cnt_next;
    logic [2:0]  idx_reg;
    logic        busy_reg;
    logic        last_reg;

    logic        s_fire, m_fire, final_byte;

    // code point selection
    logic [15:0] unit16;
    logic        unit_high, unit_low;
    logic [20:0] cp_a, cp_b;
    logic        use_a, use_b;
    logic [2:0]  na, nb;
    u16u8_pkg::enc_t enc_a, enc_b;

    assign unit16    = s_data.code_unit[15:0];
    assign unit_high = (unit16 >= u16u8_pkg::HIGH_FIRST) && (unit16 <= u16u8_pkg::HIGH_LAST);
    assign unit_low  = (unit16 >= u16u8_pkg::LOW_FIRST) && (unit16 <= u16u8_pkg::LOW_LAST);

    // first code point: pair, flushed surrogate or the unit itself; second: unit after flush
    always_comb begin
        cp_a            = s_data.code_unit;
        cp_b            = {5'd0, unit16};
        use_a           = 1'b1;
        use_b           = 1'b0;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        if (pair_reg) begin
            held_valid_next = 1'b0;
            held_next       = '0;
            if (held_valid_reg && unit_low) begin
                // surrogate pair -> supplementary plane
                cp_a = {1'b0, held_reg[9:0], unit16[9:0]} + u16u8_pkg::PLANE1_BASE;
            end else begin
                if (held_valid_reg) begin
                    cp_a = {5'd0, held_reg};
                end else begin
                    cp_a = {5'd0, unit16};
                end
                if (unit_high && !s_data.last_unit) begin
                    // hold this high surrogate until the next unit
                    held_valid_next = 1'b1;
                    held_next       = unit16;
                    use_a           = held_valid_reg;
                end else begin
                    use_b = held_valid_reg;
                    if (!held_valid_reg) begin
                        use_a = 1'b1;
                    end
                end
            end
        end
    end

    u16u8_enc u_enc_a (
        .cp  (cp_a),
        .enc (enc_a)
    );

    u16u8_enc u_enc_b (
        .cp  (cp_b),
        .enc (enc_b)
    );

    assign na = use_a ? enc_a.count : 3'd0;
    assign nb = use_b ? enc_b.count : 3'd0;

    // pack first sequence then second one behind it
    always_comb begin
        logic [2:0] kk;
        logic [2:0] bidx;
        for (int k = 0; k < u16u8_pkg::MAX_BYTES; k++) begin
            kk   = 3'(k);
            bidx = kk - na;
            if (kk < na) begin
                buf_next[k] = enc_a.bytes[kk[1:0]];
            end else if (bidx < nb) begin
                buf_next[k] = enc_b.bytes[bidx[1:0]];
            end else begin
                buf_next[k] = 8'h00;
            end
        end
        cnt_next = na + nb;
    end

    assign final_byte = (idx_reg == (cnt_reg - 3'd1));
    assign m_fire     = m_valid && m_ready;
    assign s_ready    = !busy_reg || (m_ready && final_byte);
    assign s_fire     = s_valid && s_ready;
    assign cfg_ready  = 1'b1;

    assign m_valid            = busy_reg;
    assign m_data.utf8_byte   = buf_reg[idx_reg];
    assign m_data.last_of_run = final_byte;
    assign m_data.string_end  = final_byte && last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_reg       <= 1'b1;
            held_valid_reg <= 1'b0;
            held_reg       <= '0;
            busy_reg       <= 1'b0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            last_reg       <= 1'b0;
        end else begin
            if (s_fire) begin
                buf_reg        <= buf_next;
                cnt_reg        <= cnt_next;
                idx_reg        <= '0;
                last_reg       <= s_data.last_unit;
                busy_reg       <= (cnt_next != 3'd0);
            end else if (m_fire) begin
                if (final_byte) begin
                    busy_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
            if (cfg_valid && cfg_ready) begin
                pair_reg <= cfg_data;
            end
            // mode change drops any held surrogate
            if (cfg_valid && cfg_ready && (cfg_data != pair_reg)) begin
                held_valid_reg <= 1'b0;
                held_reg       <= '0;
            end else if (s_fire) begin
                held_valid_reg <= held_valid_next;
                held_reg       <= held_next;
            end
        end
    end

`ifndef SYNTHESIS
    // a busy buffer always has a byte under the read pointer
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg != 3'd0) && (idx_reg < cnt_reg)
                     && (cnt_reg <= 3'(u16u8_pkg::MAX_BYTES)))
        else $error("serializer index out of range");

    // only a high surrogate is ever held, and only in pairing mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_valid_reg |-> pair_reg && (held_reg[15:10] == u16u8_pkg::HIGH_FIRST[15:10]))
        else $error("bad held surrogate");

    // a unit marked last never leaves a surrogate held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.last_unit && pair_reg && !(cfg_valid && cfg_data != pair_reg))
        |=> !held_valid_reg)
        else $error("surrogate held past end of string");

    // a byte that is not taken keeps the read pointer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(idx_reg))
        else $error("pending byte lost");
`endif

endmodule
